// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the generator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SSWG_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define SSWG_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  `SSWG_ASSERT(name, clk, rst_n, !(cond), msg)

`endif

// ===== hw/rtl/sswg_pkg.sv =====
`default_nettype none

package sswg_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_SAMPLES  = 3'd0,
    CFG_START_INDEX  = 3'd1,
    CFG_PULSE_LENGTH = 3'd2,
    CFG_PHASE_STEP   = 3'd3,
    CFG_AMPLITUDE    = 3'd4
  } cfg_reg_e;

  localparam int unsigned SIN_W        = 15;        // table entry, Q0.15 magnitude
  localparam int unsigned AMP_W        = 16;
  localparam int unsigned SAMPLE_W     = 18;
  localparam int unsigned WAVE_W       = 17;        // Q2.15 waveform
  localparam int unsigned NS_RST_W     = 11;        // bits needed by the reset length
  localparam int unsigned NUM_SAMPLES_RST = 1024;
  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
  localparam logic [SIN_W-1:0] SIN_MAX = 15'h7fff;

  // Unsigned 64-bit quotient by shift and subtract; evaluated at elaboration only.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine entry k of a table with 2^tab_bits steps, Q15.
  // Taylor series on a Q30 angle; evaluated at elaboration only.
  function automatic logic [SIN_W-1:0] quarter_sine(input int unsigned k,
                                                   input int unsigned tab_bits);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] dv;
    longint      acc;
    longint      q;
    if (k >= (32'd1 << tab_bits)) begin
      return SIN_MAX;
    end
    x    = (64'(k) * HALF_PI_Q30) >> tab_bits;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 10; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      dv   = 64'(2 * n) * 64'(2 * n + 1);
      term = udiv64(term, dv);
      if ((n & 1) != 0) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    q = longint'((64'(acc) + 64'd16384) >> 15);
    if (q > 32767) begin
      q = 32767;
    end
    return SIN_W'(q);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sswg_sine_rom.sv =====
`default_nettype none

module sswg_sine_rom #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic [SINE_TABLE_BITS:0]       addr_a_i,
  input  wire logic [SINE_TABLE_BITS:0]       addr_b_i,
  output logic      [sswg_pkg::SIN_W-1:0]     data_a_o,
  output logic      [sswg_pkg::SIN_W-1:0]     data_b_o
);
  import sswg_pkg::*;

  localparam int unsigned TabN = 1 << SINE_TABLE_BITS;

  typedef logic [SIN_W-1:0] tab_t [TabN+1];

  function automatic tab_t build_tab();
    tab_t t;
    for (int k = 0; k <= TabN; k++) begin
      t[k] = quarter_sine(k, SINE_TABLE_BITS);
    end
    return t;
  endfunction

  localparam tab_t SineTab = build_tab();

  logic [SIN_W-1:0] data_a_q;
  logic [SIN_W-1:0] data_b_q;

  // Two read ports, registered.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_a_q <= SineTab[addr_a_i];
      data_b_q <= SineTab[addr_b_i];
    end
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sine_source_wavelet_generator_core.sv =====
// Channel | Direction | Handshake                  | Payload
// --------+-----------+----------------------------+-----------------------------------------
// in      | request   | in_valid_i / in_stall_o    | first_of_trace_i
// out     | result    | out_valid_o / out_stall_i  | sample_o, in_trace_o, last_of_trace_o
// cfg     | write     | cfg_we_i                   | cfg_index_i, cfg_data_i
//
// One request per clock when the result side keeps up; a result reaches the output
// through the table registers and then the output register (sine table read at the
// edge that takes its request, then multiply into the output register). The trace
// counter and phase accumulator update at request time.
// Reset clears the counter and the accumulator and returns the configuration
// registers to their reset values; the sine table is constant, so there is no
// clearing pass.
// A stalled result holds in the output register while one more request still
// enters the table stage; in_stall_o rises only when both stages are full.

`default_nettype none

`include "assert_macros.svh"

module sine_source_wavelet_generator_core #(
  parameter int unsigned PHASE_BITS      = 24,
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned INDEX_BITS      = 20
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // request channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                first_of_trace_i,
  // result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [sswg_pkg::SAMPLE_W-1:0]     sample_o,
  output logic                                     in_trace_o,
  output logic                                     last_of_trace_o,
  // configuration
  input  wire logic                                cfg_we_i,
  input  wire logic [sswg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [((INDEX_BITS + 1 > PHASE_BITS)
                      ? ((INDEX_BITS + 1 > 16) ? INDEX_BITS + 1 : 16)
                      : ((PHASE_BITS > 16) ? PHASE_BITS : 16)) - 1:0] cfg_data_i
);
  import sswg_pkg::*;

  localparam int unsigned CntW  = INDEX_BITS + 1;
  localparam int unsigned NsW   = (CntW > NS_RST_W) ? CntW : NS_RST_W;
  localparam int unsigned AddrW = SINE_TABLE_BITS + 1;
  localparam int unsigned TabN  = 1 << SINE_TABLE_BITS;
  localparam int unsigned PextW = PHASE_BITS + SINE_TABLE_BITS + 2;
  localparam int unsigned ProdW = AMP_W + WAVE_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [NsW-1:0]          num_samples_q;
  logic [INDEX_BITS-1:0]   start_index_q;
  logic [INDEX_BITS-1:0]   pulse_length_q;
  logic [PHASE_BITS-1:0]   phase_step_q;
  logic signed [AMP_W-1:0] amplitude_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_samples_q  <= NsW'(NUM_SAMPLES_RST);
      start_index_q  <= '0;
      pulse_length_q <= '0;
      phase_step_q   <= '0;
      amplitude_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_NUM_SAMPLES:  num_samples_q  <= NsW'(cfg_data_i[CntW-1:0]);
        CFG_START_INDEX:  start_index_q  <= cfg_data_i[INDEX_BITS-1:0];
        CFG_PULSE_LENGTH: pulse_length_q <= cfg_data_i[INDEX_BITS-1:0];
        CFG_PHASE_STEP:   phase_step_q   <= cfg_data_i[PHASE_BITS-1:0];
        CFG_AMPLITUDE:    amplitude_q    <= $signed(cfg_data_i[AMP_W-1:0]);
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: output register, then table stage, then the request port
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic s1_valid_q;
  logic out_adv;
  logic s1_free;
  logic accept;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_free    = !s1_valid_q || out_adv;
  assign in_stall_o = !s1_free;
  assign accept     = in_valid_i && s1_free;

  // ---------------------------------------------------------------------------
  // Request stage: sample index, window, phase and table addresses
  // ---------------------------------------------------------------------------
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [PHASE_BITS-1:0] acc_q, acc_d;
  logic [CntW-1:0]       idx;
  logic [CntW-1:0]       start_ext;
  logic [CntW-1:0]       win_end;
  logic                  in_win;
  logic                  in_tr;
  logic                  last;
  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] phase2;
  logic [AddrW-1:0]      addr_a;
  logic [AddrW-1:0]      addr_b;

  // Table address of a phase: quadrant in the top two bits, then the table
  // index (padded with zeros when the phase is short); odd quadrants mirror.
  function automatic logic [AddrW-1:0] tab_addr(input logic [PHASE_BITS-1:0] p);
    logic [PextW-1:0]           pext;
    logic [SINE_TABLE_BITS-1:0] fine;
    pext = {p, {(SINE_TABLE_BITS + 2){1'b0}}};
    fine = pext[PextW-3 -: SINE_TABLE_BITS];
    if (p[PHASE_BITS-2]) begin
      return AddrW'(TabN) - {1'b0, fine};
    end
    return {1'b0, fine};
  endfunction

  always_comb begin
    idx       = first_of_trace_i ? '0 : cnt_q;
    start_ext = CntW'(start_index_q);
    win_end   = start_ext + CntW'(pulse_length_q);  // no wrap: one extra bit
    in_win    = (idx >= start_ext) && (idx <= win_end);
    phase     = (idx == start_ext) ? '0 : acc_q;
    phase2    = {phase[PHASE_BITS-2:0], 1'b0};
    in_tr     = NsW'(idx) < num_samples_q;
    last      = (num_samples_q != '0) && (NsW'(idx) == num_samples_q - NsW'(1));
    addr_a    = tab_addr(phase);
    addr_b    = tab_addr(phase2);
    // advance the phase inside the window, drop it to zero outside
    acc_d     = in_win ? (phase + phase_step_q) : '0;
    // advance the counter, saturate at all ones
    cnt_d     = (&idx) ? idx : idx + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      acc_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
      acc_q <= acc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Table stage: registered sine reads plus the flags that travel with them
  // ---------------------------------------------------------------------------
  logic [SIN_W-1:0] sin_a;
  logic [SIN_W-1:0] sin_b;
  logic             s1_neg_a_q;
  logic             s1_neg_b_q;
  logic             s1_active_q;
  logic             s1_in_trace_q;
  logic             s1_last_q;

  sswg_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk_i   (clk_i),
    .en_i    (accept),
    .addr_a_i(addr_a),
    .addr_b_i(addr_b),
    .data_a_o(sin_a),
    .data_b_o(sin_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_neg_a_q    <= phase[PHASE_BITS-1];
      s1_neg_b_q    <= phase2[PHASE_BITS-1];
      s1_active_q   <= in_win && in_tr;
      s1_in_trace_q <= in_tr;
      s1_last_q     <= last;
    end
  end

  // ---------------------------------------------------------------------------
  // Waveform and gain: w = sin(p) - floor(sin(2p)/2), sample = floor(a*w / 2^15)
  // ---------------------------------------------------------------------------
  logic signed [WAVE_W-1:0]   v_a;
  logic signed [WAVE_W-1:0]   v_b;
  logic signed [WAVE_W-1:0]   wave;
  logic signed [ProdW-1:0]    prod;
  logic signed [SAMPLE_W-1:0] sample_d;

  always_comb begin
    v_a      = s1_neg_a_q ? -$signed({2'b00, sin_a}) : $signed({2'b00, sin_a});
    v_b      = s1_neg_b_q ? -$signed({2'b00, sin_b}) : $signed({2'b00, sin_b});
    wave     = v_a - (v_b >>> 1);
    prod     = amplitude_q * wave;
    sample_d = s1_active_q ? prod[ProdW-1 -: SAMPLE_W] : '0;
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       in_trace_q;
  logic                       last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // hold the result while the far side stalls
  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      sample_q   <= sample_d;
      in_trace_q <= s1_in_trace_q;
      last_q     <= s1_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_o        = sample_q;
  assign in_trace_o      = in_trace_q;
  assign last_of_trace_o = last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SSWG_ASSERT(a_stall_only_when_full, clk_i, rst_ni,
    in_stall_o |-> (s1_valid_q && out_valid_o && out_stall_i),
    "request stalled while a stage is free")

  `SSWG_ASSERT(a_counter_steps, clk_i, rst_ni,
    (accept && !first_of_trace_i && !(&cnt_q)) |=> (cnt_q == $past(cnt_q) + CntW'(1)),
    "sample counter did not advance by one")

  `SSWG_ASSERT(a_phase_cleared, clk_i, rst_ni,
    (accept && !in_win) |=> (acc_q == '0),
    "phase accumulator not cleared outside the window")

  `SSWG_ASSERT_NEVER(a_no_sample_past_trace, clk_i, rst_ni,
    out_valid_o && !in_trace_o && (sample_o != '0),
    "nonzero sample outside the trace")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
module tb;
  import sswg_pkg::*;

  localparam int unsigned CFG_W        = 24;      // widest register: phase step
  localparam int unsigned CNT_W        = 21;
  localparam int unsigned IDX_W        = 20;
  localparam int unsigned PHASE_W      = 24;
  localparam int unsigned TAB_BITS     = 10;
  localparam int unsigned TAB_N        = 1 << TAB_BITS;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned SETTLE_CYCLES = 6;     // two pipeline stages plus margin
  localparam int unsigned RX_HOLD_CYCLES = 60;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned PRINT_CAP    = 40;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       in_trace;
    logic                       last_of_trace;
  } wavelet_sample_t;

  // Scoreboard: a bit-exact wavelet predictor plus the queue of samples it owes.
  class wavelet_scoreboard;
    logic [CNT_W-1:0]          num_samples;
    logic [IDX_W-1:0]          start_index;
    logic [IDX_W-1:0]          pulse_length;
    logic [PHASE_W-1:0]        phase_step;
    logic signed [AMP_W-1:0]   amplitude;
    logic [CNT_W-1:0]          sample_count;
    logic [PHASE_W-1:0]        phase_acc;
    int                        quarter_wave[0:TAB_N];
    wavelet_sample_t           owed_samples[$];
    int unsigned               mismatches;

    function new();
      longint unsigned x, term;
      longint          acc;
      for (int k = 0; k <= TAB_N; k++) begin
        if (k == TAB_N) begin
          quarter_wave[k] = 32767;
          continue;
        end
        x    = (64'(k) * QUARTER_TURN_Q30) >> TAB_BITS;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 10; n++) begin
          term = (term * x) >> 30;
          term = (term * x) >> 30;
          term = term / (64'(2 * n) * 64'(2 * n + 1));
          if (n % 2 == 1) acc = acc - longint'(term);
          else acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        acc = (acc + 16384) >>> 15;
        quarter_wave[k] = (acc > 32767) ? 32767 : int'(acc);
      end
      num_samples  = CNT_W'(NUM_SAMPLES_RST);
      start_index  = '0;
      pulse_length = '0;
      phase_step   = '0;
      amplitude    = '0;
      sample_count = '0;
      phase_acc    = '0;
      mismatches   = 0;
    endfunction

    function void set_reg(cfg_reg_e which, logic [CFG_W-1:0] value);
      case (which)
        CFG_NUM_SAMPLES:  num_samples  = value[CNT_W-1:0];
        CFG_START_INDEX:  start_index  = value[IDX_W-1:0];
        CFG_PULSE_LENGTH: pulse_length = value[IDX_W-1:0];
        CFG_PHASE_STEP:   phase_step   = value[PHASE_W-1:0];
        CFG_AMPLITUDE:    amplitude    = value[AMP_W-1:0];
        default: ;
      endcase
    endfunction

    // Top two phase bits pick the quadrant; odd quadrants read the table backwards.
    function int sine_at(logic [PHASE_W-1:0] p);
      logic [1:0]  quad;
      int unsigned k;
      quad = p[PHASE_W-1 -: 2];
      k    = p[PHASE_W-3 -: TAB_BITS];
      if (quad[0]) k = TAB_N - k;
      return quad[1] ? -quarter_wave[k] : quarter_wave[k];
    endfunction

    function void note_request(logic first);
      logic [CNT_W-1:0]   idx;
      logic [CNT_W-1:0]   win_end;
      logic [PHASE_W-1:0] phase;
      logic               in_win;
      int                 s1, s2, w;
      longint             prod;
      wavelet_sample_t    exp_s;
      idx     = first ? '0 : sample_count;
      win_end = {1'b0, start_index} + {1'b0, pulse_length};
      in_win  = (idx >= start_index) && (idx <= win_end);
      phase   = (idx == start_index) ? '0 : phase_acc;
      exp_s.in_trace      = idx < num_samples;
      exp_s.last_of_trace = (num_samples != 0) && (idx == num_samples - 1'b1);
      exp_s.sample        = '0;
      if (in_win && exp_s.in_trace) begin
        s1   = sine_at(phase);
        s2   = sine_at({phase[PHASE_W-2:0], 1'b0});
        w    = s1 - (s2 >>> 1);
        prod = longint'(amplitude) * longint'(w);
        exp_s.sample = SAMPLE_W'(prod >>> 15);
      end
      phase_acc    = in_win ? phase + phase_step : '0;
      sample_count = (idx != '1) ? idx + 1'b1 : idx;
      owed_samples.push_back(exp_s);
    endfunction

    task report(string what);
      if (mismatches < PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(logic signed [SAMPLE_W-1:0] smp, logic tr, logic lst);
      wavelet_sample_t exp_s;
      if (owed_samples.size() == 0) begin
        report("sample delivered with none outstanding");
        return;
      end
      exp_s = owed_samples.pop_front();
      if (smp !== exp_s.sample)
        report($sformatf("sample %0d, expected %0d", smp, exp_s.sample));
      if (tr !== exp_s.in_trace)
        report($sformatf("in_trace %0b, expected %0b", tr, exp_s.in_trace));
      if (lst !== exp_s.last_of_trace)
        report($sformatf("last_of_trace %0b, expected %0b", lst, exp_s.last_of_trace));
    endtask

    function int unsigned pending();
      return owed_samples.size();
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic                       first_of_trace_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [SAMPLE_W-1:0] sample_o;
  logic                       in_trace_o;
  logic                       last_of_trace_o;
  logic                       cfg_we_i;
  logic [CFG_IDX_W-1:0]       cfg_index_i;
  logic [CFG_W-1:0]           cfg_data_i;

  wavelet_scoreboard sb = new();

  // Knobs shared between the request driver and the result-side stall process.
  bit          no_gaps;
  bit          quiet_rx;
  int unsigned holds_asked;
  int unsigned sent;

  always #2 clk_i = ~clk_i;

  sine_source_wavelet_generator_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .first_of_trace_i (first_of_trace_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sample_o         (sample_o),
    .in_trace_o       (in_trace_o),
    .last_of_trace_o  (last_of_trace_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 0;
    if (roll < 9) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input logic first);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    first_of_trace_i <= first;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(first);
    sent++;
  endtask

  // Drop valid and wait until every owed sample is back, then let the pipe settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e which, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= value;
    @(posedge clk_i);
    sb.set_reg(which, value);
  endtask

  // Write the whole register set; only called with the block idle.
  task automatic configure(input logic [CNT_W-1:0] ns, input logic [IDX_W-1:0] st,
                           input logic [IDX_W-1:0] pl, input logic [PHASE_W-1:0] ps,
                           input logic [AMP_W-1:0] amp);
    write_reg(CFG_NUM_SAMPLES, CFG_W'(ns));
    write_reg(CFG_START_INDEX, CFG_W'(st));
    write_reg(CFG_PULSE_LENGTH, CFG_W'(pl));
    write_reg(CFG_PHASE_STEP, CFG_W'(ps));
    write_reg(CFG_AMPLITUDE, CFG_W'(amp));
    cfg_we_i <= 1'b0;
  endtask

  // Check every sample taken at this edge against the oldest prediction.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i)
      sb.check_result(sample_o, in_trace_o, last_of_trace_o);
  end

  // Result-side back-pressure: random stalls, quiet phases, and on request one long
  // hold so the two pipeline stages fill and the block stalls its request side.
  initial begin : result_stall
    int unsigned holds_done;
    holds_done  = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_asked) begin
        holds_done  = holds_asked;
        out_stall_i <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet_rx && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if no request or sample moves for too long.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [CNT_W-1:0]   ns;
    logic [IDX_W-1:0]   st, pl;
    logic [PHASE_W-1:0] ps;
    logic [AMP_W-1:0]   amp;
    int unsigned        phase_no, traces, len;
    bit                 hold_phase;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    first_of_trace_i = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = CFG_NUM_SAMPLES;
    cfg_data_i       = '0;
    no_gaps          = 1'b0;
    quiet_rx         = 1'b0;
    holds_asked      = 0;
    sent             = 0;
    phase_no         = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: 1024-sample trace, zero gain.
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    drain();

    // Short trace at full positive gain: window 2..5, last sample at 7, then
    // ticks past the end, then a restart in mid-stream.
    configure(21'd8, 20'd2, 20'd3, 24'h200000, 16'h7fff);
    send_request(1'b1);
    repeat (9) send_request(1'b0);
    send_request(1'b1);
    drain();

    // Zero trace length: nothing is ever in the trace or last.
    configure(21'd0, 20'd0, 20'hfffff, 24'hffffff, 16'h8000);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    drain();

    // Trace of 2^20 samples, widest window, most negative gain, phase step that wraps.
    configure(21'h100000, 20'd0, 20'hfffff, 24'hffffff, 16'h8000);
    send_request(1'b1);
    repeat (3) send_request(1'b0);
    drain();

    // Window end beyond the index range: the sum must not wrap.
    configure(21'h100000, 20'hfffff, 20'hfffff, 24'h123456, 16'h4000);
    send_request(1'b1);
    send_request(1'b0);
    drain();

    // Random phases: well-formed traces with random content and a sprinkle of
    // stray restarts; drain before every new register set.
    while (sent < RANDOM_ITEMS + 23) begin
      phase_no++;
      case ($urandom_range(0, 9))
        0:       ns = '0;
        1:       ns = 21'd1;
        2:       ns = CNT_W'($urandom_range(49, 1048576));
        default: ns = CNT_W'($urandom_range(2, 48));
      endcase
      case ($urandom_range(0, 9))
        0, 1:    st = IDX_W'($urandom());
        2:       st = '0;
        default: st = IDX_W'($urandom_range(0, 40));
      endcase
      case ($urandom_range(0, 9))
        0, 1:    pl = IDX_W'($urandom());
        2:       pl = '0;
        default: pl = IDX_W'($urandom_range(0, 40));
      endcase
      ps = ($urandom_range(0, 3) == 0) ? PHASE_W'($urandom_range(0, 4095))
                                       : PHASE_W'($urandom());
      case ($urandom_range(0, 9))
        0:       amp = 16'h7fff;
        1:       amp = 16'h8000;
        default: amp = AMP_W'($urandom());
      endcase
      configure(ns, st, pl, ps, amp);

      hold_phase = (phase_no == 4);
      no_gaps    = hold_phase || ($urandom_range(0, 5) == 0);
      quiet_rx   = $urandom_range(0, 5) == 0;
      if (hold_phase) holds_asked++;

      traces = $urandom_range(1, 3);
      repeat (traces) begin
        len = (ns != 0 && ns <= 48) ? ns + $urandom_range(0, 3) : $urandom_range(10, 40);
        if (hold_phase && len < 40) len = 40;
        send_request(1'b1);
        repeat (len - 1) send_request($urandom_range(0, 15) == 0);
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
